// ----- src/rgb_led_pulse_encoder_breathing_core_macros.svh -----
// Assertion macros shared by the checker of the LED line encoder.
// Both expect i_clk and i_rst_n in the scope where they are used.
`ifndef RGB_LED_PULSE_ENCODER_BREATHING_CORE_MACROS_SVH
`define RGB_LED_PULSE_ENCODER_BREATHING_CORE_MACROS_SVH

// Generic clocked assertion, off while reset is held
`define RLPE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// A stalled transaction keeps the given signal unchanged
`define RLPE_ASSERT_HOLD(lbl, vld, rdy, sig, msg) \
    `RLPE_ASSERT(lbl, ((vld) && !(rdy)) |=> $stable(sig), msg)

`endif

// ----- src/rlpe_pkg.sv -----
package rlpe_pkg;

    // Colour and segment widths
    localparam int unsigned CHAN_W     = 8;
    localparam int unsigned DUR_W      = 16;
    localparam int unsigned STEP_W     = 5;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned ITEM_BITS  = 3 * CHAN_W;
    localparam int unsigned BIT_IDX_W  = $clog2(ITEM_BITS);

    // Breathing ramp constants
    localparam logic [STEP_W-1:0] STEP_RESET = 5'd1;
    localparam logic [STEP_W-1:0] STEP_PEAK  = 5'd15;
    localparam logic [STEP_W-1:0] STEP_WRAP  = 5'd29;
    localparam logic [CHAN_W-1:0] RAMP_RED   = 8'd10;
    localparam logic [CHAN_W-1:0] RAMP_GRN_Y = 8'd6;
    localparam logic [CHAN_W-1:0] PEAK_RED   = 8'd150;
    localparam logic [CHAN_W-1:0] PEAK_GRN_Y = 8'd90;

    // Configuration register reset values
    localparam logic [DUR_W-1:0] SHORT_RST = 16'd32;
    localparam logic [DUR_W-1:0] LONG_RST  = 16'd85;
    localparam logic [DUR_W-1:0] LATCH_RST = 16'd28000;

    // Commands
    localparam logic CMD_COLOUR = 1'b0;
    localparam logic CMD_BREATH = 1'b1;

    // Configuration register map
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHORT = 2'd0,
        CFG_LONG  = 2'd1,
        CFG_LATCH = 2'd2
    } t_cfg_reg;

    // Colour in wire order: green, red, blue
    typedef struct packed {
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // One queued job for the segment generator
    typedef struct packed {
        logic latch;
        t_rgb colour;
    } t_job;

    // Segment lengths, already clamped to a minimum of one
    typedef struct packed {
        logic [DUR_W-1:0] short_len;
        logic [DUR_W-1:0] long_len;
        logic [DUR_W-1:0] latch_len;
    } t_seg_cfg;

    // Colour for one breathing step, yellow or white
    function automatic t_rgb breath_colour(input logic [STEP_W-1:0] step,
                                           input logic yellow);
        t_rgb c;
        logic [CHAN_W-1:0] s8;
        logic [CHAN_W-1:0] d8;
        s8 = CHAN_W'(step);
        d8 = CHAN_W'(step - STEP_PEAK);
        if (step <= STEP_PEAK) begin
            c.red   = s8 * RAMP_RED;
            c.green = yellow ? s8 * RAMP_GRN_Y : c.red;
        end else begin
            c.red   = PEAK_RED - d8 * RAMP_RED;
            c.green = yellow ? PEAK_GRN_Y - d8 * RAMP_GRN_Y : c.red;
        end
        c.blue = yellow ? '0 : c.red;
        return c;
    endfunction

endpackage

// ----- src/rlpe_if.sv -----
// Input item channel
interface rlpe_item_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       breath_yellow;

    modport source (output valid, command, red, green, blue, breath_yellow,
                    input ready);
    modport sink   (input valid, command, red, green, blue, breath_yellow,
                    output ready);
endinterface

// Line segment channel
interface rlpe_seg_if;
    logic        valid;
    logic        ready;
    logic        line_level;
    logic [15:0] duration;
    logic        last_segment;

    modport source (output valid, line_level, duration, last_segment, input ready);
    modport sink   (input valid, line_level, duration, last_segment, output ready);
endinterface

// Configuration write channel
interface rlpe_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- src/rlpe_front.sv -----
module rlpe_front import rlpe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rlpe_item_if.sink    i_item,
    input  logic         i_q_full,
    output logic         o_q_push,
    output t_job         o_q_job
);

    logic [STEP_W-1:0] r_breath_step;
    logic [STEP_W-1:0] n_breath_step;
    logic [STEP_W-1:0] step_inc;
    t_rgb              breath_rgb;

    // Accept whenever the queue has room
    assign i_item.ready = !i_q_full;
    assign o_q_push     = i_item.valid && !i_q_full;

    // Classify: plain colour or one breathing step with latch pulse
    always_comb begin
        step_inc      = r_breath_step + 1'b1;
        breath_rgb    = breath_colour(step_inc, i_item.breath_yellow);
        n_breath_step = r_breath_step;
        o_q_job.latch = (i_item.command == CMD_BREATH);
        if (i_item.command == CMD_BREATH) begin
            o_q_job.colour = breath_rgb;
            n_breath_step  = (step_inc >= STEP_WRAP) ? STEP_RESET : step_inc;
        end else begin
            o_q_job.colour.green = i_item.green;
            o_q_job.colour.red   = i_item.red;
            o_q_job.colour.blue  = i_item.blue;
        end
    end

    // Step counter advances on each accepted breathing transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_breath_step <= STEP_RESET;
        end else if (o_q_push && (i_item.command == CMD_BREATH)) begin
            r_breath_step <= n_breath_step;
        end
    end

endmodule

// ----- src/rlpe_fifo.sv -----
module rlpe_fifo import rlpe_pkg::*; #(
    parameter int unsigned DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_job              r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/rlpe_back.sv -----
module rlpe_back import rlpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_seg_cfg    i_cfg,
    input  logic        i_q_valid,
    input  t_job        i_q_job,
    output logic        o_q_pop,
    rlpe_seg_if.source  o_seg
);

    logic                 r_busy;
    logic                 r_latch;
    logic                 r_half;
    logic [ITEM_BITS-1:0] r_bits;
    logic [BIT_IDX_W-1:0] r_bit_idx;
    logic                 r_out_valid;
    logic                 r_level;
    logic [DUR_W-1:0]     r_dur;
    logic                 r_last;

    logic                 adv;
    logic                 done_item;
    logic                 load;
    logic                 bit_one;
    logic                 last_bit;
    logic                 n_level;
    logic [DUR_W-1:0]     n_dur;
    logic                 n_last;

    // Next segment from the job in progress
    always_comb begin
        adv       = r_busy && (!r_out_valid || o_seg.ready);
        bit_one   = r_bits[ITEM_BITS-1];
        last_bit  = (r_bit_idx == BIT_IDX_W'(ITEM_BITS - 1));
        done_item = adv && !r_latch && r_half && last_bit;
        load      = i_q_valid && (!r_busy || done_item);
        if (r_latch) begin
            n_level = 1'b0;
            n_dur   = i_cfg.latch_len;
            n_last  = 1'b0;
        end else if (!r_half) begin
            n_level = 1'b1;
            n_dur   = bit_one ? i_cfg.long_len : i_cfg.short_len;
            n_last  = 1'b0;
        end else begin
            n_level = 1'b0;
            n_dur   = bit_one ? i_cfg.short_len : i_cfg.long_len;
            n_last  = last_bit;
        end
    end

    assign o_q_pop = load;

    // Job sequencer: optional latch pulse, then two segments per bit, MSB first
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_latch   <= 1'b0;
            r_half    <= 1'b0;
            r_bit_idx <= '0;
        end else if (load) begin
            r_busy    <= 1'b1;
            r_latch   <= i_q_job.latch;
            r_half    <= 1'b0;
            r_bit_idx <= '0;
        end else if (adv) begin
            if (r_latch) begin
                r_latch <= 1'b0;
            end else if (r_half) begin
                r_half    <= 1'b0;
                r_bit_idx <= r_bit_idx + 1'b1;
                if (last_bit) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_half <= 1'b1;
            end
        end
    end

    // Colour shift register
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_bits <= i_q_job.colour;
        end else if (adv && !r_latch && r_half) begin
            r_bits <= {r_bits[ITEM_BITS-2:0], 1'b0};
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_seg.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_level <= n_level;
            r_dur   <= n_dur;
            r_last  <= n_last;
        end
    end

    assign o_seg.valid        = r_out_valid;
    assign o_seg.line_level   = r_level;
    assign o_seg.duration     = r_dur;
    assign o_seg.last_segment = r_last;

endmodule

// ----- src/rgb_led_pulse_encoder_breathing_core.sv -----
// Single-wire RGB LED line encoder with breathing generator.
// i_item (valid/ready) takes commands: command 0 sends red/green/blue as
// given; command 1 advances the breathing step and sends a latch low pulse
// followed by the breathing colour (yellow or white by breath_yellow).
// o_seg (valid/ready) gives line segments: level, duration in clock cycles,
// and last_segment on the final segment of each input transaction.
// Colours go out green, red, blue, MSB first; each bit is a high and a low
// segment, long/short for a one, short/long for a zero.
// i_cfg writes segment lengths: 0 short, 1 long, 2 latch; a zero length
// is taken as one. Write it only while the block is idle.
// An accepted item passes through the queue, the job sequencer and the
// output register. Throughput: one segment per cycle from the generator
// unless o_seg stalls; 48 segments per colour command, 49 per breathing.
// A queue of QUEUE_DEPTH jobs sits between decode and the generator, so
// items are accepted while earlier ones are still being sent.
// A receiver stall holds the output segment and halts the generator; once the
// queue fills, i_item.ready drops. Reset clears the queue, the output and the
// breathing step (to 1), and restores the default segment lengths.
module rgb_led_pulse_encoder_breathing_core import rlpe_pkg::*; #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rlpe_item_if.sink   i_item,
    rlpe_cfg_if.sink    i_cfg,
    rlpe_seg_if.source  o_seg
);

    logic [DUR_W-1:0] r_short_cycles;
    logic [DUR_W-1:0] r_long_cycles;
    logic [DUR_W-1:0] r_latch_cycles;
    t_seg_cfg         seg_cfg;

    logic q_full;
    logic q_push;
    t_job q_in_job;
    logic q_pop;
    logic q_valid;
    t_job q_out_job;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_cycles <= SHORT_RST;
            r_long_cycles  <= LONG_RST;
            r_latch_cycles <= LATCH_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_SHORT: r_short_cycles <= i_cfg.data;
                CFG_LONG:  r_long_cycles  <= i_cfg.data;
                CFG_LATCH: r_latch_cycles <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    // A segment length is never below one
    always_comb begin
        seg_cfg.short_len = (r_short_cycles == '0) ? DUR_W'(1) : r_short_cycles;
        seg_cfg.long_len  = (r_long_cycles == '0) ? DUR_W'(1) : r_long_cycles;
        seg_cfg.latch_len = (r_latch_cycles == '0) ? DUR_W'(1) : r_latch_cycles;
    end

    rlpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_job  (q_in_job)
    );

    rlpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    rlpe_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (seg_cfg),
        .i_q_valid (q_valid),
        .i_q_job   (q_out_job),
        .o_q_pop   (q_pop),
        .o_seg     (o_seg)
    );

endmodule

// ----- src/rlpe_checker.sv -----
`include "rgb_led_pulse_encoder_breathing_core_macros.svh"

module rlpe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic        i_level,
    input logic [15:0] i_duration,
    input logic        i_last
);

    // Stalled segment keeps its duration
    `RLPE_ASSERT_HOLD(a_dur_hold, i_valid, i_ready, i_duration, "duration changed under stall")

    // Every segment has a nonzero duration
    `RLPE_ASSERT(a_dur_nonzero, i_valid |-> (i_duration != 16'd0), "zero length segment")

    // Final segment of a transaction is always a low segment
    `RLPE_ASSERT(a_last_low, (i_valid && i_last) |-> !i_level, "last segment driven high")

    // A high segment is always followed by the low half of the same bit
    `RLPE_ASSERT(a_high_then_low, (i_valid && i_ready && i_level) |=> !(i_valid && i_level), "two high segments in a row")

endmodule

bind rgb_led_pulse_encoder_breathing_core rlpe_checker u_rlpe_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (o_seg.valid),
    .i_ready    (o_seg.ready),
    .i_level    (o_seg.line_level),
    .i_duration (o_seg.duration),
    .i_last     (o_seg.last_segment)
);
